### rtl/mtms_pkg.sv
// Shared types and constants for the message transmit mode scheduler.
// Depends on nothing; every design file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mtms_pkg;

	// Default widths of the running counters.
	localparam int TIMER_WIDTH_DEF  = 16;
	localparam int REPEAT_WIDTH_DEF = 8;

	// Fixed widths of the configuration port and of the configuration fields.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_TIME_W  = 16;
	localparam int CFG_COUNT_W = 8;
	localparam int MSG_TYPE_W  = 3;

	// Operation carried by an input word.
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_TRIGGER = 2'd1,
		OP_START   = 2'd2,
		OP_STOP    = 2'd3
	} op_t;

	// Transmission modes. Codes 5 to 7 are undefined and never send.
	localparam logic [MSG_TYPE_W-1:0] MT_PERIODIC     = 3'd0;
	localparam logic [MSG_TYPE_W-1:0] MT_ON_EVENT     = 3'd1;
	localparam logic [MSG_TYPE_W-1:0] MT_IF_ACTIVE    = 3'd2;
	localparam logic [MSG_TYPE_W-1:0] MT_PER_OR_EVENT = 3'd3;
	localparam logic [MSG_TYPE_W-1:0] MT_PER_ACTIVE   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_MSG_TYPE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_TIME      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FAST_CYCLE_TIME = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_TIME     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DELAY_TIME  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_TX_ENABLE       = 3'd7;

	// Contents of the configuration register bank.
	typedef struct packed {
		logic [MSG_TYPE_W-1:0]  msg_type;
		logic [CFG_TIME_W-1:0]  cycle_time;
		logic [CFG_TIME_W-1:0]  fast_cycle_time;
		logic [CFG_TIME_W-1:0]  repeat_time;
		logic [CFG_TIME_W-1:0]  min_delay_time;
		logic [CFG_COUNT_W-1:0] repeat_count;
		logic [CFG_TIME_W-1:0]  start_offset;
		logic                   tx_enable;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/message_tx_mode_scheduler.sv
// Top level of the message transmit mode scheduler: input stage, result register, handshakes.
// Depends on mtms_pkg, mtms_cfg_regs and mtms_sched_core.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_ready     op, active_value
//   result    out        result_valid / result_ready send, status
//   cfg       in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// An accepted word waits in the input register and its result then waits in the result
// register until it is taken. The scheduler state is updated in the cycle in which a
// word moves from the input register to the result register, so one word per cycle is
// sustained while results are taken. The result register is the only stall point:
// while it holds an untaken result the input register keeps its word, and item_ready
// drops only when both are full. Reset clears the valid flags, the scheduler state and
// the configuration to zero, but not the op, send and status data fields. Configuration
// writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module message_tx_mode_scheduler #(
	parameter int TIMER_WIDTH  = mtms_pkg::TIMER_WIDTH_DEF,
	parameter int REPEAT_WIDTH = mtms_pkg::REPEAT_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire logic [1:0]                       op,
	input  wire logic                             active_value,

	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output logic                                  send,
	output logic                                  status,

	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mtms_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mtms_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Input register. It holds one word until the result register can take its result.
	logic           valid_s1;
	mtms_pkg::op_t  op_s1;
	logic           act_s1;

	// Result register.
	logic           result_valid_q;
	logic           send_q;
	logic           status_q;

	logic           advance;
	logic           core_send;
	logic           core_status;
	mtms_pkg::cfg_t cfg;

	// A word moves on when the result register is empty or is being emptied.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1  <= mtms_pkg::op_t'(op);
			act_s1 <= active_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			send_q   <= core_send;
			status_q <= core_status;
		end
	end

	assign result_valid = result_valid_q;
	assign send         = send_q;
	assign status       = status_q;

	mtms_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mtms_sched_core #(
		.TIMER_WIDTH  (TIMER_WIDTH),
		.REPEAT_WIDTH (REPEAT_WIDTH)
	) u_sched_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.op     (op_s1),
		.act    (act_s1),
		.cfg    (cfg),
		.send   (core_send),
		.status (core_status)
	);

`ifndef SYNTH
	// Only a trigger can be rejected, and only a tick can send.
	a_status_only_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		advance && core_status |-> op_s1 == mtms_pkg::OP_TRIGGER)
		else $error("status set for a word that is not a trigger");

	a_send_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && core_send |-> op_s1 == mtms_pkg::OP_TICK)
		else $error("send set for a word that is not a tick");

	// A word that moves on always leaves a valid result behind.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("result register empty after a word moved on");

	// The input register keeps its word while the result side stalls.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(act_s1))
		else $error("input register lost a stalled word");

	// Backpressure appears only when both registers are full and the output stalls.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && result_valid_q && !result_ready)
		else $error("item_ready low without a full stalled pipeline");
`endif

endmodule

`default_nettype wire

### rtl/mtms_cfg_regs.sv
// Configuration register bank of the message transmit mode scheduler.
// Depends on mtms_pkg for the register indexes and the cfg_t layout.
`timescale 1ns / 1ps
`default_nettype none

module mtms_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [mtms_pkg::CFG_INDEX_W-1:0] wr_index,
	input  wire logic [mtms_pkg::CFG_DATA_W-1:0]  wr_data,
	output mtms_pkg::cfg_t                     cfg
);

	mtms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mtms_pkg::CFG_MSG_TYPE: begin
					cfg_q.msg_type <= wr_data[mtms_pkg::MSG_TYPE_W-1:0];
				end
				mtms_pkg::CFG_CYCLE_TIME: begin
					cfg_q.cycle_time <= wr_data[mtms_pkg::CFG_TIME_W-1:0];
				end
				mtms_pkg::CFG_FAST_CYCLE_TIME: begin
					cfg_q.fast_cycle_time <= wr_data[mtms_pkg::CFG_TIME_W-1:0];
				end
				mtms_pkg::CFG_REPEAT_TIME: begin
					cfg_q.repeat_time <= wr_data[mtms_pkg::CFG_TIME_W-1:0];
				end
				mtms_pkg::CFG_MIN_DELAY_TIME: begin
					cfg_q.min_delay_time <= wr_data[mtms_pkg::CFG_TIME_W-1:0];
				end
				mtms_pkg::CFG_REPEAT_COUNT: begin
					cfg_q.repeat_count <= wr_data[mtms_pkg::CFG_COUNT_W-1:0];
				end
				mtms_pkg::CFG_START_OFFSET: begin
					cfg_q.start_offset <= wr_data[mtms_pkg::CFG_TIME_W-1:0];
				end
				mtms_pkg::CFG_TX_ENABLE: begin
					cfg_q.tx_enable <= wr_data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/mtms_sched_core.sv
// Scheduler state and its update for one input word, taken into the state registers on fire.
// Depends on mtms_pkg for op_t, the mode codes and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module mtms_sched_core #(
	parameter int TIMER_WIDTH  = mtms_pkg::TIMER_WIDTH_DEF,
	parameter int REPEAT_WIDTH = mtms_pkg::REPEAT_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire mtms_pkg::op_t op,
	input  wire logic          act,
	input  wire mtms_pkg::cfg_t cfg,
	output logic               send,
	output logic               status
);

	logic                    started_q, active_q, delayed_q;
	logic [TIMER_WIDTH-1:0]  cycle_timer_q, repeat_timer_q, min_delay_timer_q;
	logic [REPEAT_WIDTH-1:0] repeats_left_q;

	logic                    started_d, active_d, delayed_d;
	logic [TIMER_WIDTH-1:0]  cycle_timer_d, repeat_timer_d, min_delay_timer_d;
	logic [REPEAT_WIDTH-1:0] repeats_left_d;

	// Timers after the tick decrement, saturating at zero.
	logic [TIMER_WIDTH-1:0]  ct_dec, rt_dec, md_dec;
	logic                    ct_zero, rt_zero, md_zero;

	// Configuration values at the counter widths.
	logic [TIMER_WIDTH-1:0]  ld_cycle, ld_fast, ld_repeat, ld_min_delay, ld_offset;
	logic [REPEAT_WIDTH-1:0] rep_count;

	assign ld_cycle     = TIMER_WIDTH'(cfg.cycle_time);
	assign ld_fast      = TIMER_WIDTH'(cfg.fast_cycle_time);
	assign ld_repeat    = TIMER_WIDTH'(cfg.repeat_time);
	assign ld_min_delay = TIMER_WIDTH'(cfg.min_delay_time);
	assign ld_offset    = TIMER_WIDTH'(cfg.start_offset);
	assign rep_count    = REPEAT_WIDTH'(cfg.repeat_count);

	assign ct_dec = (cycle_timer_q == '0) ? cycle_timer_q
		: cycle_timer_q - TIMER_WIDTH'(1);
	assign rt_dec = (repeat_timer_q == '0) ? repeat_timer_q
		: repeat_timer_q - TIMER_WIDTH'(1);
	assign md_dec = (min_delay_timer_q == '0) ? min_delay_timer_q
		: min_delay_timer_q - TIMER_WIDTH'(1);

	assign ct_zero = (ct_dec == '0);
	assign rt_zero = (rt_dec == '0);
	assign md_zero = (md_dec == '0);

	always_comb begin
		started_d         = started_q;
		active_d          = active_q;
		delayed_d         = delayed_q;
		cycle_timer_d     = cycle_timer_q;
		repeat_timer_d    = repeat_timer_q;
		min_delay_timer_d = min_delay_timer_q;
		repeats_left_d    = repeats_left_q;
		send              = 1'b0;
		status            = 1'b0;

		case (op)
			mtms_pkg::OP_TICK: begin
				cycle_timer_d     = ct_dec;
				repeat_timer_d    = rt_dec;
				min_delay_timer_d = md_dec;
				if (cfg.tx_enable && started_q) begin
					case (cfg.msg_type)
						mtms_pkg::MT_PERIODIC: begin
							if (ct_zero) begin
								cycle_timer_d = ld_cycle;
								send          = 1'b1;
							end
						end
						mtms_pkg::MT_ON_EVENT: begin
							if (repeats_left_q != '0 && rt_zero && md_zero) begin
								repeats_left_d    = repeats_left_q - REPEAT_WIDTH'(1);
								repeat_timer_d    = ld_repeat;
								min_delay_timer_d = ld_min_delay;
								send              = 1'b1;
							end
						end
						mtms_pkg::MT_IF_ACTIVE: begin
							if (active_q) begin
								if (ct_zero && md_zero) begin
									cycle_timer_d     = ld_fast;
									min_delay_timer_d = ld_min_delay;
									send              = 1'b1;
								end
							end else if (repeats_left_q != '0 && rt_zero && md_zero) begin
								repeats_left_d    = repeats_left_q - REPEAT_WIDTH'(1);
								repeat_timer_d    = ld_repeat;
								min_delay_timer_d = ld_min_delay;
								send              = 1'b1;
							end
						end
						mtms_pkg::MT_PER_OR_EVENT: begin
							if (repeats_left_q == '0) begin
								// A periodic send inside the minimum delay is held back
								// until the delay runs out.
								if (ct_zero) begin
									cycle_timer_d = ld_cycle;
									if (md_zero) begin
										send = 1'b1;
									end else begin
										delayed_d = 1'b1;
									end
								end else if (delayed_q && md_zero) begin
									delayed_d = 1'b0;
									send      = 1'b1;
								end
							end else if (rt_zero && md_zero) begin
								repeats_left_d    = repeats_left_q - REPEAT_WIDTH'(1);
								repeat_timer_d    = ld_repeat;
								min_delay_timer_d = ld_min_delay;
								send              = 1'b1;
							end
						end
						mtms_pkg::MT_PER_ACTIVE: begin
							if (active_q || repeats_left_q == '0) begin
								if (ct_zero && md_zero) begin
									cycle_timer_d     = active_q ? ld_fast : ld_cycle;
									min_delay_timer_d = ld_min_delay;
									send              = 1'b1;
								end
							end else if (rt_zero && md_zero) begin
								// The first repetition restarts the normal period.
								if (repeats_left_q == rep_count) begin
									cycle_timer_d = ld_cycle;
								end
								repeats_left_d    = repeats_left_q - REPEAT_WIDTH'(1);
								repeat_timer_d    = ld_repeat;
								min_delay_timer_d = ld_min_delay;
								send              = 1'b1;
							end
						end
						default: begin
							send = 1'b0;
						end
					endcase
				end
			end
			mtms_pkg::OP_TRIGGER: begin
				if (!started_q) begin
					status = 1'b1;
				end else begin
					case (cfg.msg_type)
						mtms_pkg::MT_ON_EVENT, mtms_pkg::MT_PER_OR_EVENT: begin
							repeat_timer_d = '0;
							repeats_left_d = rep_count;
						end
						mtms_pkg::MT_IF_ACTIVE, mtms_pkg::MT_PER_ACTIVE: begin
							active_d = act;
							if (act) begin
								cycle_timer_d = '0;
							end else begin
								repeats_left_d = rep_count;
								repeat_timer_d = '0;
							end
						end
						default: begin
							status = 1'b1;
						end
					endcase
				end
			end
			mtms_pkg::OP_START: begin
				cycle_timer_d = ld_offset;
				started_d     = 1'b1;
			end
			mtms_pkg::OP_STOP: begin
				started_d = 1'b0;
			end
			default: begin
				started_d = started_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q         <= 1'b0;
			active_q          <= 1'b0;
			delayed_q         <= 1'b0;
			cycle_timer_q     <= '0;
			repeat_timer_q    <= '0;
			min_delay_timer_q <= '0;
			repeats_left_q    <= '0;
		end else if (fire) begin
			started_q         <= started_d;
			active_q          <= active_d;
			delayed_q         <= delayed_d;
			cycle_timer_q     <= cycle_timer_d;
			repeat_timer_q    <= repeat_timer_d;
			min_delay_timer_q <= min_delay_timer_d;
			repeats_left_q    <= repeats_left_d;
		end
	end

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the message transmit mode scheduler: directed and random words.
// Depends on mtms_pkg and message_tx_mode_scheduler, which needs the other design files.
`timescale 1ns / 1ps

module tb_top;
	import mtms_pkg::*;

	localparam int TW = TIMER_WIDTH_DEF;
	localparam int RW = REPEAT_WIDTH_DEF;

	// One result word as the block should return it.
	typedef struct packed {
		logic send;
		logic status;
	} word_result_t;

	// Clock and the single reset at the start of the run.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #10 clk = ~clk;

	// Every input of the block starts at a known value.
	logic                   item_valid   = 1'b0;
	logic [1:0]             op           = OP_TICK;
	logic                   active_value = 1'b0;
	logic                   result_ready = 1'b0;
	logic                   cfg_valid    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = CFG_MSG_TYPE;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   item_ready;
	logic                   result_valid;
	logic                   send;
	logic                   status;
	logic                   cfg_ready;

	message_tx_mode_scheduler uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.op          (op),
		.active_value(active_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.send        (send),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Shadow copy of the register bank and of the scheduler state. All of it
	// comes out of reset at zero, exactly like the block.
	cfg_t            cfg_mirror    = '0;
	logic            sch_started   = 1'b0;
	logic [TW-1:0]   sch_cycle_tmr = '0;
	logic [TW-1:0]   sch_rep_tmr   = '0;
	logic [TW-1:0]   sch_gap_tmr   = '0;
	logic [RW-1:0]   sch_reps_left = '0;
	logic            sch_active    = 1'b0;
	logic            sch_deferred  = 1'b0;

	// Results still owed by the block, oldest first.
	word_result_t pending_results[$];
	word_result_t oldest_result;

	// Bookkeeping shared by the stimulus and the result checker.
	int  errors           = 0;
	int  n_words          = 0;
	int  n_results        = 0;
	int  n_sends          = 0;
	int  n_rejects        = 0;
	int  n_settings       = 0;
	int  stall_left       = 0;
	int  long_hold_cycles = 0;
	bit  idle_on          = 1'b1;

	// Timers count down and stick at zero.
	function automatic logic [TW-1:0] timer_down(input logic [TW-1:0] t);
		return (t != '0) ? t - 1'b1 : '0;
	endfunction

	// A repeated event send goes out only when both the repeat spacing and
	// the minimum delay have run out; it reloads both of them.
	function automatic logic fire_repetition();
		if (sch_rep_tmr == '0 && sch_gap_tmr == '0) begin
			sch_reps_left = sch_reps_left - 1'b1;
			sch_rep_tmr   = cfg_mirror.repeat_time;
			sch_gap_tmr   = cfg_mirror.min_delay_time;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// A periodic send that also honors and restarts the minimum delay.
	function automatic logic fire_cycle(input logic [TW-1:0] period);
		if (sch_cycle_tmr == '0 && sch_gap_tmr == '0) begin
			sch_cycle_tmr = period;
			sch_gap_tmr   = cfg_mirror.min_delay_time;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the shadow scheduler by one word and returns the result word
	// the block has to produce for it.
	function automatic word_result_t predict_word(input op_t o, input logic act);
		word_result_t w;
		w = '0;
		case (o)
			OP_TICK: begin
				// Timers run down first, whether or not the slot is started.
				sch_cycle_tmr = timer_down(sch_cycle_tmr);
				sch_rep_tmr   = timer_down(sch_rep_tmr);
				sch_gap_tmr   = timer_down(sch_gap_tmr);
				if (cfg_mirror.tx_enable && sch_started) begin
					case (cfg_mirror.msg_type)
						MT_PERIODIC: begin
							if (sch_cycle_tmr == '0) begin
								sch_cycle_tmr = cfg_mirror.cycle_time;
								w.send = 1'b1;
							end
						end
						MT_ON_EVENT: begin
							if (sch_reps_left != '0)
								w.send = fire_repetition();
						end
						MT_IF_ACTIVE: begin
							if (sch_active)
								w.send = fire_cycle(cfg_mirror.fast_cycle_time);
							else if (sch_reps_left != '0)
								w.send = fire_repetition();
						end
						MT_PER_OR_EVENT: begin
							// A periodic send inside the minimum delay is held back
							// until the delay ends, and it never restarts the delay.
							if (sch_reps_left != '0) begin
								w.send = fire_repetition();
							end else if (sch_cycle_tmr == '0) begin
								sch_cycle_tmr = cfg_mirror.cycle_time;
								if (sch_gap_tmr == '0)
									w.send = 1'b1;
								else
									sch_deferred = 1'b1;
							end else if (sch_deferred && sch_gap_tmr == '0) begin
								sch_deferred = 1'b0;
								w.send = 1'b1;
							end
						end
						MT_PER_ACTIVE: begin
							if (sch_active) begin
								w.send = fire_cycle(cfg_mirror.fast_cycle_time);
							end else if (sch_reps_left == '0) begin
								w.send = fire_cycle(cfg_mirror.cycle_time);
							end else if (sch_rep_tmr == '0 && sch_gap_tmr == '0) begin
								// The first repetition of a burst restarts the period.
								if (sch_reps_left == cfg_mirror.repeat_count)
									sch_cycle_tmr = cfg_mirror.cycle_time;
								w.send = fire_repetition();
							end
						end
						default: begin
							// Undefined modes never send.
						end
					endcase
				end
			end
			OP_TRIGGER: begin
				if (!sch_started) begin
					w.status = 1'b1;
				end else begin
					case (cfg_mirror.msg_type)
						MT_ON_EVENT, MT_PER_OR_EVENT: begin
							sch_rep_tmr   = '0;
							sch_reps_left = cfg_mirror.repeat_count;
						end
						MT_IF_ACTIVE, MT_PER_ACTIVE: begin
							if (act) begin
								sch_active    = 1'b1;
								sch_cycle_tmr = '0;
							end else begin
								sch_active    = 1'b0;
								sch_reps_left = cfg_mirror.repeat_count;
								sch_rep_tmr   = '0;
							end
						end
						default: begin
							// Periodic and undefined modes refuse triggers.
							w.status = 1'b1;
						end
					endcase
				end
			end
			OP_START: begin
				sch_cycle_tmr = cfg_mirror.start_offset;
				sch_started   = 1'b1;
			end
			default: begin
				sch_started = 1'b0;
			end
		endcase
		return w;
	endfunction

	// Offers one word on the item channel after an optional random gap and
	// holds it until the block takes it. The valid is left high on return,
	// so the caller either sends the next word or drains in the same step.
	task automatic send_word(input op_t o, input logic act);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		op           <= o;
		active_value <= act;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		pending_results.push_back(predict_word(o, act));
		n_words++;
	endtask

	// Writes one register and mirrors it. The valid stays high on return;
	// the caller lowers it after its last write.
	task automatic cfg_write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_MSG_TYPE:        cfg_mirror.msg_type        = data[MSG_TYPE_W-1:0];
			CFG_CYCLE_TIME:      cfg_mirror.cycle_time      = data;
			CFG_FAST_CYCLE_TIME: cfg_mirror.fast_cycle_time = data;
			CFG_REPEAT_TIME:     cfg_mirror.repeat_time     = data;
			CFG_MIN_DELAY_TIME:  cfg_mirror.min_delay_time  = data;
			CFG_REPEAT_COUNT:    cfg_mirror.repeat_count    = data[CFG_COUNT_W-1:0];
			CFG_START_OFFSET:    cfg_mirror.start_offset    = data;
			default:             cfg_mirror.tx_enable       = data[0];
		endcase
	endtask

	// Loads the whole register bank; only called while the block is idle.
	task automatic write_config(input cfg_t c);
		cfg_write_reg(CFG_MSG_TYPE,        CFG_DATA_W'(c.msg_type));
		cfg_write_reg(CFG_CYCLE_TIME,      c.cycle_time);
		cfg_write_reg(CFG_FAST_CYCLE_TIME, c.fast_cycle_time);
		cfg_write_reg(CFG_REPEAT_TIME,     c.repeat_time);
		cfg_write_reg(CFG_MIN_DELAY_TIME,  c.min_delay_time);
		cfg_write_reg(CFG_REPEAT_COUNT,    CFG_DATA_W'(c.repeat_count));
		cfg_write_reg(CFG_START_OFFSET,    c.start_offset);
		cfg_write_reg(CFG_TX_ENABLE,       CFG_DATA_W'(c.tx_enable));
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Stops offering words and waits until every owed result has come back,
	// then lets the two register stages settle.
	task automatic wait_for_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: checks each accepted word against the oldest expectation
	// and shapes result_ready. A long hold-off requested by a test takes
	// priority over the random stall bursts.
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				if (errors < 10)
					$display("[%0t] unexpected result word: send=%0b status=%0b",
						$realtime, send, status);
				errors++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (send !== oldest_result.send || status !== oldest_result.status) begin
					if (errors < 10)
						$display("[%0t] result mismatch: expected send=%0b status=%0b, got send=%0b status=%0b",
							$realtime, oldest_result.send, oldest_result.status, send, status);
					errors++;
				end
				if (oldest_result.send)
					n_sends++;
				if (oldest_result.status)
					n_rejects++;
			end
		end
		if (long_hold_cycles > 0) begin
			result_ready <= 1'b0;
			long_hold_cycles--;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			result_ready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// With the reset configuration: a stopped slot ignores ticks, refuses
	// triggers and shrugs off a stop; a started periodic slot still refuses
	// triggers, and with transmission disabled a tick sends nothing.
	task automatic test_stopped_and_periodic();
		send_word(OP_TICK, 1'b0);
		send_word(OP_TRIGGER, 1'b0);
		send_word(OP_STOP, 1'b1);
		send_word(OP_START, 1'b0);
		send_word(OP_TRIGGER, 1'b1);
		send_word(OP_TICK, 1'b1);
		wait_for_results();
	endtask

	// All-ones data on the mode register selects an undefined mode: the
	// trigger is refused and the tick never sends. The longest minimum delay
	// is written here, where no send can load it.
	task automatic test_undefined_mode();
		cfg_write_reg(CFG_MSG_TYPE, '1);
		cfg_write_reg(CFG_TX_ENABLE, '1);
		cfg_write_reg(CFG_MIN_DELAY_TIME, '1);
		cfg_valid <= 1'b0;
		send_word(OP_TRIGGER, 1'b1);
		send_word(OP_TICK, 1'b0);
		wait_for_results();
	endtask

	// On-event mode: a trigger while transmission is disabled is still
	// accepted, and once enabled the two repetitions go out back to back.
	task automatic test_event_while_disabled();
		cfg_t c;
		c = '0;
		c.msg_type     = MT_ON_EVENT;
		c.cycle_time   = 16'd3;
		c.repeat_count = 8'd2;
		write_config(c);
		send_word(OP_TRIGGER, 1'b0);
		wait_for_results();
		cfg_write_reg(CFG_TX_ENABLE, 16'd1);
		cfg_valid <= 1'b0;
		repeat (3) send_word(OP_TICK, 1'b0);
		wait_for_results();
	endtask

	// Periodic-or-event: a repetition arms the minimum delay, the periodic
	// send that falls inside it is held back and goes out when it ends.
	task automatic test_deferred_periodic();
		cfg_t c;
		c = '0;
		c.msg_type       = MT_PER_OR_EVENT;
		c.cycle_time     = 16'd3;
		c.min_delay_time = 16'd3;
		c.repeat_count   = 8'd1;
		c.tx_enable      = 1'b1;
		write_config(c);
		send_word(OP_START, 1'b0);
		send_word(OP_TRIGGER, 1'b0);
		repeat (4) send_word(OP_TICK, 1'b1);
		wait_for_results();
	endtask

	// Periodic-active with every time and count but the minimum delay at its
	// maximum: a restart of a started slot, both trigger flavors, and a double stop.
	task automatic test_counter_extremes();
		cfg_t c;
		c.msg_type        = MT_PER_ACTIVE;
		c.cycle_time      = '1;
		c.fast_cycle_time = '1;
		c.repeat_time     = '1;
		c.min_delay_time  = '0;
		c.repeat_count    = '1;
		c.start_offset    = '1;
		c.tx_enable       = 1'b1;
		write_config(c);
		send_word(OP_START, 1'b0);
		send_word(OP_START, 1'b1);
		send_word(OP_TRIGGER, 1'b0);
		send_word(OP_TICK, 1'b0);
		send_word(OP_TRIGGER, 1'b1);
		send_word(OP_TICK, 1'b1);
		send_word(OP_STOP, 1'b0);
		send_word(OP_STOP, 1'b1);
		wait_for_results();
	endtask

	// The receiver holds off for a long stretch while words keep coming, so
	// both register stages fill and item_ready has to drop. Periodic mode
	// with a zero period sends on every tick.
	task automatic test_back_pressure();
		cfg_t c;
		c = '0;
		c.msg_type  = MT_PERIODIC;
		c.tx_enable = 1'b1;
		write_config(c);
		long_hold_cycles = 100;
		send_word(OP_START, 1'b0);
		repeat (30) send_word(OP_TICK, 1'($urandom_range(0, 1)));
		wait_for_results();
	endtask

	// Mostly short periods so that sends happen often, now and then a zero,
	// a full-scale or an arbitrary value.
	function automatic logic [CFG_TIME_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2)
			return CFG_TIME_W'($urandom_range(0, 65535));
		return CFG_TIME_W'($urandom_range(1, 8));
	endfunction

	// Random register settings, each followed by a run of words: usually a
	// start, then mostly ticks with triggers mixed in and the odd start or
	// stop. The minimum delay stays short, since a long one would silence
	// the slot for the rest of the run.
	task automatic test_random_traffic(input int phases, input bit with_idling);
		cfg_t c;
		int   r;
		op_t  o;
		idle_on = with_idling;
		for (int p = 0; p < phases; p++) begin
			r = $urandom_range(0, 11);
			c.msg_type        = (r < 10) ? MSG_TYPE_W'(r % 5) : MSG_TYPE_W'($urandom_range(5, 7));
			c.cycle_time      = pick_period();
			c.fast_cycle_time = pick_period();
			c.repeat_time     = pick_period();
			c.start_offset    = pick_period();
			c.min_delay_time  = ($urandom_range(0, 7) == 0) ?
				CFG_TIME_W'($urandom_range(0, 20)) : CFG_TIME_W'($urandom_range(0, 4));
			r = $urandom_range(0, 9);
			if (r == 0)
				c.repeat_count = '0;
			else if (r == 1)
				c.repeat_count = '1;
			else if (r == 2)
				c.repeat_count = CFG_COUNT_W'($urandom_range(0, 255));
			else
				c.repeat_count = CFG_COUNT_W'($urandom_range(1, 5));
			c.tx_enable = ($urandom_range(0, 7) != 0);
			write_config(c);
			if ($urandom_range(0, 9) != 0)
				send_word(OP_START, 1'($urandom_range(0, 1)));
			for (int k = 0; k < 50; k++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					o = OP_TICK;
				else if (r < 88)
					o = OP_TRIGGER;
				else if (r < 95)
					o = OP_START;
				else
					o = OP_STOP;
				send_word(o, 1'($urandom_range(0, 1)));
			end
			wait_for_results();
		end
	endtask

	initial begin : main_sequence
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stopped_and_periodic();
		test_undefined_mode();
		test_event_while_disabled();
		test_deferred_periodic();
		test_counter_extremes();
		test_back_pressure();
		test_random_traffic(24, 1'b1);
		// The last stretch runs with both sides always willing.
		test_random_traffic(6, 1'b0);

		// Anything still owed after the drain counts as a failure.
		repeat (10) @(posedge clk);
		errors += pending_results.size();

		$display("Ran %0d words under %0d register settings, all five modes and undefined ones.",
			n_words, n_settings);
		$display("Checked %0d result words: %0d sends, %0d refused triggers, %0d mismatches.",
			n_results, n_sends, n_rejects, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Far beyond the slowest correct run, including the long hold-off.
	initial begin : watchdog
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### message_tx_mode_scheduler.f
rtl/mtms_pkg.sv
rtl/mtms_cfg_regs.sv
rtl/mtms_sched_core.sv
rtl/message_tx_mode_scheduler.sv
verif/tb_top.sv
